// ===== rtl/svpc_pkg.sv =====
// Package for the SVPWM compare generator.
// Shared types and constants for the front end, queue, back end and top level.
// No dependencies.
`default_nettype none

package svpc_pkg;

	localparam int FIFO_DEPTH_DEF = 2;
	localparam int CFG_W = 16;

	localparam logic [14:0] BUS_COEFF_RST  = 15'd4096;
	localparam logic [14:0] PERIOD_MAX_RST = 15'd4096;
	localparam logic [15:0] PERIOD_MOD_RST = 16'd32767;

	localparam logic signed [15:0] Q_LIMIT   = 16'sd30500;
	localparam logic signed [15:0] D_LIMIT   = 16'sd6500;
	localparam logic signed [15:0] C_SQRT3_2 = 16'sd28377;
	localparam logic [15:0] C_HALF = 16'd16384;

	typedef enum logic [1:0] {
		REG_BUS_COEFF  = 2'd0,
		REG_PERIOD_MAX = 2'd1,
		REG_PERIOD_MOD = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0]        angle;
		logic signed [15:0] ds;
		logic signed [15:0] qs;
	} job_t;

	typedef struct packed {
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
		logic [15:0] cmp_c;
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
		logic [2:0]  sector;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/svpc_in_if.sv =====
// Input channel of the SVPWM compare generator: angle and d/q commands.
// Uses no package.
`default_nettype none

interface svpc_in_if;
	logic        valid;
	logic        ready;
	logic [14:0] angle;
	logic [15:0] volt_d;
	logic [15:0] volt_q;

	modport source (output valid, output angle, output volt_d, output volt_q, input ready);
	modport sink (input valid, input angle, input volt_d, input volt_q, output ready);
endinterface

`default_nettype wire

// ===== rtl/svpc_out_if.sv =====
// Output channel of the SVPWM compare generator: compares, duties and sector.
// Uses no package.
`default_nettype none

interface svpc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cmp_a;
	logic [15:0] cmp_b;
	logic [15:0] cmp_c;
	logic [15:0] duty_a;
	logic [15:0] duty_b;
	logic [15:0] duty_c;
	logic [2:0]  sector;

	modport source (output valid, output cmp_a, output cmp_b, output cmp_c,
		output duty_a, output duty_b, output duty_c, output sector, input ready);
	modport sink (input valid, input cmp_a, input cmp_b, input cmp_c,
		input duty_a, input duty_b, input duty_c, input sector, output ready);
endinterface

`default_nettype wire

// ===== rtl/svpc_front.sv =====
// Front end: accepts input items, scales and clamps the d/q commands.
// Depends on svpc_pkg and svpc_in_if.
`default_nettype none

module svpc_front import svpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	svpc_in_if.sink          cmd,
	input  wire logic [14:0] bus_coeff,
	output job_t             job,
	output logic             job_valid,
	input  wire logic        job_ready
);

	logic               valid_s1;
	logic [14:0]        angle_s1;
	logic signed [31:0] pd_s1;
	logic signed [31:0] pq_s1;
	logic signed [15:0] sd;
	logic signed [15:0] sq;

	assign cmd.ready = !valid_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			angle_s1 <= cmd.angle;
			pd_s1    <= $signed(cmd.volt_d) * $signed({1'b0, bus_coeff});
			pq_s1    <= $signed(cmd.volt_q) * $signed({1'b0, bus_coeff});
		end
	end

	always_comb begin
		sd = pd_s1[27:12];
		sq = pq_s1[27:12];
		if (sd > D_LIMIT) begin
			sd = D_LIMIT;
		end else if (sd < -D_LIMIT) begin
			sd = -D_LIMIT;
		end
		if (sq > Q_LIMIT) begin
			sq = Q_LIMIT;
		end else if (sq < -Q_LIMIT) begin
			sq = -Q_LIMIT;
		end
	end

	assign job.angle = angle_s1;
	assign job.ds    = sd;
	assign job.qs    = sq;
	assign job_valid = valid_s1;

endmodule

`default_nettype wire

// ===== rtl/svpc_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on svpc_pkg.
`default_nettype none

module svpc_fifo import svpc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	output logic      full,
	input  wire logic pop,
	output job_t      head,
	output logic      not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH) || pop)) else $error("push into full queue");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("count lost a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/svpc_sine.sv =====
// Iterative sine unit: round(32767*sin(2*pi*angle/32768)) from a Horner series
// in Q62 on one shared 32x32 multiplier. Depends on svpc_pkg.
`default_nettype none

module svpc_sine import svpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [14:0] angle,
	output logic             done,
	output logic [15:0]      value
);

	localparam int TERMS = 8;
	localparam logic [62:0] ONE = 63'd1 << 62;
	localparam logic [49:0] PI_STEP = 50'(64'hC90FDAA22168C235 >> 14);
	localparam logic [62:0] R_SIN [TERMS] = '{ONE / 63'd6, ONE / 63'd20, ONE / 63'd42,
		ONE / 63'd72, ONE / 63'd110, ONE / 63'd156, ONE / 63'd210, ONE / 63'd272};
	localparam logic [62:0] R_COS [TERMS] = '{ONE / 63'd2, ONE / 63'd12, ONE / 63'd30,
		ONE / 63'd56, ONE / 63'd90, ONE / 63'd132, ONE / 63'd182, ONE / 63'd240};

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_X    = 7'b0000010,
		ST_X2   = 7'b0000100,
		ST_MH   = 7'b0001000,
		ST_MR   = 7'b0010000,
		ST_MX   = 7'b0100000,
		ST_RND  = 7'b1000000
	} sin_state_t;

	sin_state_t   state_q;
	logic [12:0]  m_q;
	logic         cos_q;
	logic         neg_q;
	logic [2:0]   kidx_q;
	logic [1:0]   cnt_q;
	logic [125:0] acc_q;
	logic [62:0]  x_q;
	logic [62:0]  x2_q;
	logic [62:0]  h_q;
	logic [62:0]  t_q;
	logic         done_q;
	logic [15:0]  value_q;

	logic [13:0]  mm;
	logic [62:0]  op_a;
	logic [62:0]  op_b;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;
	logic [125:0] pp_sh;
	logic [125:0] acc_next;
	logic [62:0]  mul_res;
	logic [62:0]  rp;
	logic [16:0]  v;
	logic [14:0]  mag;

	assign mm = angle[13] ? (14'd8192 - {1'b0, angle[12:0]}) : {1'b0, angle[12:0]};

	always_comb begin
		op_a = x_q;
		op_b = x_q;
		case (state_q)
			ST_MH: begin
				op_a = h_q;
				op_b = x2_q;
			end
			ST_MR: begin
				op_a = t_q;
				op_b = cos_q ? R_COS[kidx_q] : R_SIN[kidx_q];
			end
			ST_MX: begin
				op_a = h_q;
				op_b = x_q;
			end
			default: begin
			end
		endcase
		a_half = cnt_q[1] ? {1'b0, op_a[62:32]} : op_a[31:0];
		b_half = cnt_q[0] ? {1'b0, op_b[62:32]} : op_b[31:0];
		pp = a_half * b_half;
		case (cnt_q)
			2'd0:    pp_sh = 126'(pp);
			2'd3:    pp_sh = 126'(pp) << 64;
			default: pp_sh = 126'(pp) << 32;
		endcase
		acc_next = acc_q + pp_sh;
		mul_res  = acc_next[124:62];
		rp  = 63'(h_q[62:16] * 15'd32767) + (63'd1 << 45);
		v   = rp[62:46];
		mag = (v > 17'd32767) ? 15'h7FFF : v[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_X;
					end
				end
				ST_X: begin
					state_q <= ST_X2;
				end
				ST_X2, ST_MH, ST_MR, ST_MX: begin
					cnt_q <= cnt_q + 1'b1;
					acc_q <= (cnt_q == 2'd3) ? '0 : acc_next;
					if (cnt_q == 2'd3) begin
						if (state_q == ST_X2 || state_q == ST_MR) begin
							state_q <= ST_MH;
						end
						if (state_q == ST_MH) begin
							state_q <= ST_MR;
						end
						if (state_q == ST_MR && kidx_q == '0) begin
							state_q <= cos_q ? ST_RND : ST_MX;
						end
						if (state_q == ST_MX) begin
							state_q <= ST_RND;
						end
					end
				end
				ST_RND: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q <= angle[14];
			if (mm <= 14'd4096) begin
				m_q   <= mm[12:0];
				cos_q <= 1'b0;
			end else begin
				m_q   <= 13'(14'd8192 - mm);
				cos_q <= 1'b1;
			end
		end
		if (state_q == ST_X) begin
			x_q <= 63'(m_q * PI_STEP);
		end
		if (cnt_q == 2'd3) begin
			if (state_q == ST_X2) begin
				x2_q   <= mul_res;
				h_q    <= ONE;
				kidx_q <= 3'(TERMS - 1);
			end
			if (state_q == ST_MH) begin
				t_q <= mul_res;
			end
			if (state_q == ST_MR) begin
				h_q    <= ONE - mul_res;
				kidx_q <= kidx_q - 1'b1;
			end
			if (state_q == ST_MX) begin
				h_q <= mul_res;
			end
		end
		if (state_q == ST_RND) begin
			value_q <= neg_q ? 16'(-{1'b0, mag}) : {1'b0, mag};
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

`default_nettype wire

// ===== rtl/svpc_back.sv =====
// Back end: sine and cosine, inverse Park, sector and duties, compare values,
// and the output register. Depends on svpc_pkg and svpc_sine.
`default_nettype none

module svpc_back import svpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  job_t             job,
	input  wire logic        job_valid,
	output logic             job_pop,
	input  wire logic [15:0] mper,
	output result_t          res,
	output logic             res_valid,
	input  wire logic        res_ready
);

	typedef enum logic [9:0] {
		B_IDLE = 10'b0000000001,
		B_SIN  = 10'b0000000010,
		B_COS  = 10'b0000000100,
		B_S1   = 10'b0000001000,
		B_S2   = 10'b0000010000,
		B_S3   = 10'b0000100000,
		B_S4   = 10'b0001000000,
		B_S5   = 10'b0010000000,
		B_WB   = 10'b0100000000,
		B_HOLD = 10'b1000000000
	} back_state_t;

	back_state_t        state_q;
	job_t               job_q;
	logic signed [15:0] sn_q;
	logic signed [15:0] cs_q;
	logic signed [31:0] p_dc_s1;
	logic signed [31:0] p_qs_s1;
	logic signed [31:0] p_qc_s1;
	logic signed [31:0] p_ds_s1;
	logic [15:0]        ua_s2;
	logic [15:0]        ub_s2;
	logic signed [31:0] p_r_s3;
	logic [15:0]        ub_s3;
	logic [15:0]        duty_a_s4;
	logic [15:0]        duty_b_s4;
	logic [15:0]        duty_c_s4;
	logic [2:0]         sector_s4;
	logic signed [31:0] pa_s5;
	logic signed [31:0] pb_s5;
	logic signed [31:0] pc_s5;
	result_t            res_q;
	logic               res_valid_q;

	logic               sin_start;
	logic [14:0]        sin_angle;
	logic               sin_done;
	logic [15:0]        sin_value;
	logic               wb_load;

	logic [15:0] r16, hn, hp, vb, vc, y, z, x, t1, t2, base, ta, tb, tc, mhalf;
	logic [16:0] nub;
	logic [17:0] s18;
	logic [2:0]  sec;

	svpc_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sin_start),
		.angle  (sin_angle),
		.done   (sin_done),
		.value  (sin_value)
	);

	assign job_pop   = (state_q == B_IDLE) && job_valid;
	assign sin_start = job_pop || (state_q == B_SIN && sin_done);
	assign sin_angle = (state_q == B_IDLE) ? job.angle : job_q.angle + 15'd8192;
	assign wb_load   = (state_q == B_WB) && (!res_valid_q || res_ready);

	always_comb begin
		r16 = p_r_s3[30:15];
		nub = 17'd0 - {ub_s3[15], ub_s3};
		hn  = nub[16:1];
		hp  = {ub_s3[15], ub_s3[15:1]};
		x   = ub_s3;
		vb  = hn + r16;
		vc  = hn - r16;
		y   = hp + r16;
		z   = hp - r16;
		sec = {!vc[15] && vc != '0, !vb[15] && vb != '0, !x[15] && x != '0};
		if (sec == 3'd7) begin
			sec = 3'd0;
		end
		case (sec)
			3'd1: begin
				t1 = z;
				t2 = y;
			end
			3'd2: begin
				t1 = y;
				t2 = -x;
			end
			3'd3: begin
				t1 = -z;
				t2 = x;
			end
			3'd4: begin
				t1 = -x;
				t2 = z;
			end
			3'd5: begin
				t1 = x;
				t2 = -y;
			end
			3'd6: begin
				t1 = -y;
				t2 = -z;
			end
			default: begin
				t1 = '0;
				t2 = '0;
			end
		endcase
		s18  = 18'd32768 - {{2{t1[15]}}, t1} - {{2{t2[15]}}, t2};
		base = s18[16:1];
		ta = C_HALF;
		tb = C_HALF;
		tc = C_HALF;
		case (sec)
			3'd1: begin
				tb = base;
				ta = tb + t1;
				tc = ta + t2;
			end
			3'd2: begin
				ta = base;
				tc = ta + t1;
				tb = tc + t2;
			end
			3'd3: begin
				ta = base;
				tb = ta + t1;
				tc = tb + t2;
			end
			3'd4: begin
				tc = base;
				tb = tc + t1;
				ta = tb + t2;
			end
			3'd5: begin
				tb = base;
				tc = tb + t1;
				ta = tc + t2;
			end
			3'd6: begin
				tc = base;
				ta = tc + t1;
				tb = ta + t2;
			end
			default: begin
			end
		endcase
		mhalf = {mper[15], mper[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (wb_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= B_SIN;
					end
				end
				B_SIN: begin
					if (sin_done) begin
						state_q <= B_COS;
					end
				end
				B_COS: begin
					if (sin_done) begin
						state_q <= B_S1;
					end
				end
				B_S1:   state_q <= B_S2;
				B_S2:   state_q <= B_S3;
				B_S3:   state_q <= B_S4;
				B_S4:   state_q <= B_S5;
				B_S5:   state_q <= B_WB;
				B_WB: begin
					if (wb_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == B_SIN && sin_done) begin
			sn_q <= sin_value;
		end
		if (state_q == B_COS && sin_done) begin
			cs_q <= sin_value;
		end
		if (state_q == B_S1) begin
			p_dc_s1 <= job_q.ds * cs_q;
			p_qs_s1 <= job_q.qs * sn_q;
			p_qc_s1 <= job_q.qs * cs_q;
			p_ds_s1 <= job_q.ds * sn_q;
		end
		if (state_q == B_S2) begin
			ua_s2 <= p_dc_s1[30:15] - p_qs_s1[30:15];
			ub_s2 <= p_qc_s1[30:15] + p_ds_s1[30:15];
		end
		if (state_q == B_S3) begin
			p_r_s3 <= C_SQRT3_2 * $signed(ua_s2);
			ub_s3  <= ub_s2;
		end
		if (state_q == B_S4) begin
			duty_a_s4 <= (ta - C_HALF) << 1;
			duty_b_s4 <= (tb - C_HALF) << 1;
			duty_c_s4 <= (tc - C_HALF) << 1;
			sector_s4 <= sec;
		end
		if (state_q == B_S5) begin
			pa_s5 <= $signed(mper) * $signed(duty_a_s4);
			pb_s5 <= $signed(mper) * $signed(duty_b_s4);
			pc_s5 <= $signed(mper) * $signed(duty_c_s4);
		end
		if (wb_load) begin
			res_q.cmp_a  <= pa_s5[31:16] + mhalf;
			res_q.cmp_b  <= pb_s5[31:16] + mhalf;
			res_q.cmp_c  <= pc_s5[31:16] + mhalf;
			res_q.duty_a <= duty_a_s4;
			res_q.duty_b <= duty_b_s4;
			res_q.duty_c <= duty_c_s4;
			res_q.sector <= sector_s4;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== rtl/svpwm_compare_generator.sv =====
// Top level of the SVPWM compare generator: configuration registers, period
// modulation, front end, queue and back end. Depends on svpc_pkg, the channel
// interfaces, svpc_front, svpc_fifo and svpc_back.
//
// Usage: items on cmd carry a Q15 angle and d/q voltage commands; each one
// yields exactly one item on rsp with three compare values, three Q15 duties
// and the sector. Both channels move an item when valid and ready are high.
// The back end takes one item at a time and pops the next only after it has
// loaded the last result into the output register. The sine and the cosine
// from the shared Q62 series unit take 35 multiplies of four 32x32 partial
// products each plus setup and rounding, then the transform and compare
// arithmetic runs through states B_S1 to B_S5 and B_WB. The front stage and
// the queue take up to FIFO_DEPTH + 1 items ahead of the back end, three by
// default, so cmd.ready stays high while a result waits on rsp until both
// are full. If rsp is stalled the result holds in the output register and
// the back end finishes the next item and waits with it. Reset clears all
// control state and loads the registers with their defaults. The user makes
// configuration writes while the block is idle, which is not enforced.
`default_nettype none

module svpwm_compare_generator import svpc_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	svpc_in_if.sink               cmd,
	svpc_out_if.source            rsp,
	input  wire logic             cfg_wen,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	logic [14:0]        bus_coeff_q;
	logic [14:0]        period_max_q;
	logic [15:0]        period_mod_q;
	logic signed [31:0] mprod_q;
	logic [15:0]        mper_q;

	job_t    fe_job;
	logic    fe_valid;
	logic    fifo_full;
	job_t    fifo_head;
	logic    fifo_nempty;
	logic    be_pop;
	result_t be_res;
	logic    be_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_coeff_q  <= BUS_COEFF_RST;
			period_max_q <= PERIOD_MAX_RST;
			period_mod_q <= PERIOD_MOD_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_BUS_COEFF:  bus_coeff_q  <= cfg_wdata[14:0];
				REG_PERIOD_MAX: period_max_q <= cfg_wdata[14:0];
				REG_PERIOD_MOD: period_mod_q <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mprod_q <= $signed({1'b0, period_max_q}) * $signed(period_mod_q);
		mper_q  <= mprod_q[31:16] + {2'b00, period_max_q[14:1]};
	end

	svpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.bus_coeff (bus_coeff_q),
		.job       (fe_job),
		.job_valid (fe_valid),
		.job_ready (!fifo_full)
	);

	svpc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_valid && !fifo_full),
		.push_data (fe_job),
		.full      (fifo_full),
		.pop       (be_pop),
		.head      (fifo_head),
		.not_empty (fifo_nempty)
	);

	svpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (fifo_head),
		.job_valid (fifo_nempty),
		.job_pop   (be_pop),
		.mper      (mper_q),
		.res       (be_res),
		.res_valid (be_valid),
		.res_ready (rsp.ready)
	);

	assign rsp.valid  = be_valid;
	assign rsp.cmp_a  = be_res.cmp_a;
	assign rsp.cmp_b  = be_res.cmp_b;
	assign rsp.cmp_c  = be_res.cmp_c;
	assign rsp.duty_a = be_res.duty_a;
	assign rsp.duty_b = be_res.duty_b;
	assign rsp.duty_c = be_res.duty_c;
	assign rsp.sector = be_res.sector;

endmodule

`default_nettype wire
